// ===== rtl/mbte_pkg.sv =====
package mbte_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int TOP_W       = 12;

  localparam logic [63:0]      MOD_RESET = 64'd1000000007;
  localparam logic [TOP_W-1:0] TOP_RESET = 12'd4095;

  // request codes
  localparam logic [2:0] REQ_BUILD = 3'd0;
  localparam logic [2:0] REQ_NCR   = 3'd1;
  localparam logic [2:0] REQ_NPR   = 3'd2;
  localparam logic [2:0] REQ_CAT   = 3'd3;
  localparam logic [2:0] REQ_STARS = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NB    = 2'd2;

  // config register indexes
  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_TOP     = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] n_arg;
    logic [31:0] r_arg;
  } mbte_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } mbte_out_t;

  // (a + b) mod m for a, b < m
  function automatic logic [63:0] add_m(input logic [63:0] a, input logic [63:0] b,
                                        input logic [63:0] m);
    logic [63:0] gap;
    gap = m - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

endpackage

// ===== rtl/modular_binomial_table_engine.sv =====
// Build: a forward factorial sweep, a modular exponentiation, then a backward inverse sweep;
//   Catalan queries also run an exponentiation to invert n+1.
// Throughput: one item at a time; every multiply is a 64-bit shift-add unit, 1 bit/cycle.
// Reset (synchronous, rst_n low) sets modulus 1000000007, table top 4095, tables not built.
// Table memories are not cleared; their contents are only used after a build has written them.
module modular_binomial_table_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbte_pkg::mbte_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mbte_pkg::mbte_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_wdata
);
  import mbte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BINIT, S_BFW, S_PTEST, S_PAW, S_PBW, S_BIW,
    S_QDEC, S_QRD1, S_QRD2, S_QM1W, S_QM2W, S_CBW, S_CFW, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [63:0]      mod_r;
  logic [TOP_W-1:0] top_r;

  // modulus and top latched by the last build
  logic [63:0]       mm_r;
  logic [ADDR_W-1:0] bt_r;
  logic              ready_r;

  // table memories, one write and one read port each
  logic [63:0]       fact_mem  [TABLE_DEPTH];
  logic [63:0]       ifact_mem [TABLE_DEPTH];
  logic              fwe_r, iwe_r;
  logic [ADDR_W-1:0] fwaddr_r, iwaddr_r;
  logic [63:0]       fwdata_r, iwdata_r;
  logic [ADDR_W-1:0] fact_raddr, ifact_raddr;
  logic [63:0]       fact_q, ifact_q;

  // shared shift-add modular multiplier
  logic        mul_run_r;
  logic [63:0] mul_a_r, mul_b_r, mul_acc_r;
  logic [5:0]  mul_cnt_r;
  logic [63:0] mul_dbl, mul_step;

  // working registers
  mbte_in_t          req_r;
  logic [ADDR_W-1:0] i_r, rr_r;
  logic [63:0]       pacc_r, pbase_r, pe_r;
  logic              pcat_r;
  logic [63:0]       f_r, x_r, v_r;
  mbte_out_t         res_r, out_r;
  logic              out_valid_r;

  logic [63:0] one;
  logic [32:0] q_nn, q_rr, q_diff;
  logic        q_imm;
  logic [1:0]  q_st;
  logic [63:0] q_val;

  localparam logic [5:0] CNT_FULL  = 6'd63;
  localparam logic [5:0] CNT_SHORT = 6'(ADDR_W - 1);

  assign one = (mm_r == 64'd1) ? 64'd0 : 64'd1;

  // one multiplier bit per cycle: acc = 2*acc + bit*a (mod m)
  always_comb begin
    mul_dbl  = add_m(mul_acc_r, mul_acc_r, mm_r);
    mul_step = mul_b_r[mul_cnt_r] ? add_m(mul_dbl, mul_a_r, mm_r) : mul_dbl;
  end

  // query decode: range checks and table addresses
  always_comb begin
    q_nn  = 33'(req_r.n_arg);
    q_rr  = 33'(req_r.r_arg);
    q_imm = 1'b0;
    q_st  = ST_OK;
    q_val = 64'd0;
    // unknown codes answer zero, ok, even before a build
    if (!ready_r && req_r.req_type <= REQ_STARS) begin
      q_imm = 1'b1;
      q_st  = ST_NB;
    end else begin
      case (req_r.req_type)
        REQ_NCR, REQ_NPR: begin
          if (req_r.r_arg > req_r.n_arg) begin
            q_imm = 1'b1;
          end else if (q_nn > 33'(bt_r)) begin
            q_imm = 1'b1;
            q_st  = ST_RANGE;
          end
        end
        REQ_CAT: begin
          q_nn = {req_r.n_arg, 1'b0};
          q_rr = 33'(req_r.n_arg);
          if (q_nn > 33'(bt_r)) begin
            q_imm = 1'b1;
            q_st  = ST_RANGE;
          end
        end
        REQ_STARS: begin
          if (req_r.r_arg == 32'd0) begin
            q_imm = 1'b1;
            q_val = (req_r.n_arg == 32'd0) ? one : 64'd0;
          end else begin
            q_nn = 33'(req_r.n_arg) + 33'(req_r.r_arg) - 33'd1;
            q_rr = 33'(req_r.r_arg) - 33'd1;
            if (q_nn > 33'(bt_r)) begin
              q_imm = 1'b1;
              q_st  = ST_RANGE;
            end
          end
        end
        default: begin
          q_imm = 1'b1;
        end
      endcase
    end
    q_diff = q_nn - q_rr;
  end

  assign fact_raddr  = q_nn[ADDR_W-1:0];
  assign ifact_raddr = (state_r == S_QRD1) ? rr_r : q_diff[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (fwe_r) begin
      fact_mem[fwaddr_r] <= fwdata_r;
    end
    fact_q <= fact_mem[fact_raddr];
  end

  always_ff @(posedge clk) begin
    if (iwe_r) begin
      ifact_mem[iwaddr_r] <= iwdata_r;
    end
    ifact_q <= ifact_mem[ifact_raddr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      mul_run_r   <= 1'b0;
      fwe_r       <= 1'b0;
      iwe_r       <= 1'b0;
      mod_r       <= MOD_RESET;
      top_r       <= TOP_RESET;
      mm_r        <= 64'd1;
      bt_r        <= '0;
    end else begin
      fwe_r <= 1'b0;
      iwe_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_MODULUS: mod_r <= cfg_wdata;
          CFG_TOP:     top_r <= cfg_wdata[TOP_W-1:0];
          default:     ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (mul_run_r) begin
        mul_acc_r <= mul_step;
        if (mul_cnt_r == 6'd0) begin
          mul_run_r <= 1'b0;
        end else begin
          mul_cnt_r <= mul_cnt_r - 6'd1;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            if (in_data.req_type == REQ_BUILD) begin
              mm_r    <= (mod_r < 64'd2) ? 64'd1 : mod_r;
              bt_r    <= (32'(top_r) > TABLE_DEPTH - 1) ? ADDR_W'(TABLE_DEPTH - 1)
                                                        : ADDR_W'(top_r);
              state_r <= S_BINIT;
            end else begin
              state_r <= S_QDEC;
            end
          end
        end

        // forward sweep: fact[i] = fact[i-1] * i
        S_BINIT: begin
          fwe_r    <= 1'b1;
          fwaddr_r <= '0;
          fwdata_r <= one;
          i_r      <= ADDR_W'(1);
          if (bt_r == '0) begin
            pbase_r <= one;
            pacc_r  <= one;
            pe_r    <= mm_r - 64'd2;
            pcat_r  <= 1'b0;
            state_r <= S_PTEST;
          end else begin
            mul_a_r   <= one;
            mul_b_r   <= 64'd1;
            mul_cnt_r <= CNT_SHORT;
            mul_acc_r <= '0;
            mul_run_r <= 1'b1;
            state_r   <= S_BFW;
          end
        end

        S_BFW: begin
          if (!mul_run_r) begin
            fwe_r    <= 1'b1;
            fwaddr_r <= i_r;
            fwdata_r <= mul_acc_r;
            if (i_r == bt_r) begin
              pbase_r <= mul_acc_r;
              pacc_r  <= one;
              pe_r    <= mm_r - 64'd2;
              pcat_r  <= 1'b0;
              state_r <= S_PTEST;
            end else begin
              i_r       <= i_r + ADDR_W'(1);
              mul_a_r   <= mul_acc_r;
              mul_b_r   <= 64'(i_r) + 64'd1;
              mul_cnt_r <= CNT_SHORT;
              mul_acc_r <= '0;
              mul_run_r <= 1'b1;
            end
          end
        end

        // square-and-multiply, exponent consumed from the low end
        S_PTEST: begin
          if (pe_r == 64'd0) begin
            if (pcat_r) begin
              mul_a_r   <= v_r;
              mul_b_r   <= pacc_r;
              mul_cnt_r <= CNT_FULL;
              mul_acc_r <= '0;
              mul_run_r <= 1'b1;
              state_r   <= S_CFW;
            end else begin
              iwe_r    <= 1'b1;
              iwaddr_r <= bt_r;
              iwdata_r <= pacc_r;
              i_r      <= bt_r;
              if (bt_r == '0) begin
                ready_r      <= 1'b1;
                res_r.value  <= '0;
                res_r.status <= ST_OK;
                state_r      <= S_DONE;
              end else begin
                mul_a_r   <= pacc_r;
                mul_b_r   <= 64'(bt_r);
                mul_cnt_r <= CNT_SHORT;
                mul_acc_r <= '0;
                mul_run_r <= 1'b1;
                state_r   <= S_BIW;
              end
            end
          end else begin
            mul_a_r   <= pe_r[0] ? pacc_r : pbase_r;
            mul_b_r   <= pbase_r;
            mul_cnt_r <= CNT_FULL;
            mul_acc_r <= '0;
            mul_run_r <= 1'b1;
            state_r   <= pe_r[0] ? S_PAW : S_PBW;
          end
        end

        S_PAW: begin
          if (!mul_run_r) begin
            pacc_r    <= mul_acc_r;
            mul_a_r   <= pbase_r;
            mul_b_r   <= pbase_r;
            mul_cnt_r <= CNT_FULL;
            mul_acc_r <= '0;
            mul_run_r <= 1'b1;
            state_r   <= S_PBW;
          end
        end

        S_PBW: begin
          if (!mul_run_r) begin
            pbase_r <= mul_acc_r;
            pe_r    <= pe_r >> 1;
            state_r <= S_PTEST;
          end
        end

        // backward sweep: ifact[i-1] = ifact[i] * i
        S_BIW: begin
          if (!mul_run_r) begin
            iwe_r    <= 1'b1;
            iwaddr_r <= i_r - ADDR_W'(1);
            iwdata_r <= mul_acc_r;
            if (i_r == ADDR_W'(1)) begin
              ready_r      <= 1'b1;
              res_r.value  <= '0;
              res_r.status <= ST_OK;
              state_r      <= S_DONE;
            end else begin
              i_r       <= i_r - ADDR_W'(1);
              mul_a_r   <= mul_acc_r;
              mul_b_r   <= 64'(i_r) - 64'd1;
              mul_cnt_r <= CNT_SHORT;
              mul_acc_r <= '0;
              mul_run_r <= 1'b1;
            end
          end
        end

        S_QDEC: begin
          rr_r <= q_rr[ADDR_W-1:0];
          if (q_imm) begin
            res_r.value  <= q_val;
            res_r.status <= q_st;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_QRD1;
          end
        end

        S_QRD1: begin
          f_r <= fact_q;
          x_r <= ifact_q;
          if (req_r.req_type == REQ_NPR) begin
            mul_a_r   <= ifact_q;
            mul_b_r   <= fact_q;
            mul_cnt_r <= CNT_FULL;
            mul_acc_r <= '0;
            mul_run_r <= 1'b1;
            state_r   <= S_QM2W;
          end else begin
            state_r <= S_QRD2;
          end
        end

        S_QRD2: begin
          mul_a_r   <= x_r;
          mul_b_r   <= ifact_q;
          mul_cnt_r <= CNT_FULL;
          mul_acc_r <= '0;
          mul_run_r <= 1'b1;
          state_r   <= S_QM1W;
        end

        S_QM1W: begin
          if (!mul_run_r) begin
            mul_a_r   <= mul_acc_r;
            mul_b_r   <= f_r;
            mul_cnt_r <= CNT_FULL;
            mul_acc_r <= '0;
            mul_run_r <= 1'b1;
            state_r   <= S_QM2W;
          end
        end

        S_QM2W: begin
          if (!mul_run_r) begin
            if (req_r.req_type == REQ_CAT) begin
              // reduce n+1 mod m before inverting it
              v_r       <= mul_acc_r;
              mul_a_r   <= one;
              mul_b_r   <= 64'(req_r.n_arg[ADDR_W-1:0]) + 64'd1;
              mul_cnt_r <= CNT_SHORT;
              mul_acc_r <= '0;
              mul_run_r <= 1'b1;
              state_r   <= S_CBW;
            end else begin
              res_r.value  <= mul_acc_r;
              res_r.status <= ST_OK;
              state_r      <= S_DONE;
            end
          end
        end

        S_CBW: begin
          if (!mul_run_r) begin
            pbase_r <= mul_acc_r;
            pacc_r  <= one;
            pe_r    <= mm_r - 64'd2;
            pcat_r  <= 1'b1;
            state_r <= S_PTEST;
          end
        end

        S_CFW: begin
          if (!mul_run_r) begin
            res_r.value  <= mul_acc_r;
            res_r.status <= ST_OK;
            state_r      <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_r       <= res_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.value == 64'd0)
    else $error("error result with nonzero value");

  a_mul_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_run_r |-> state_r == S_BFW || state_r == S_PAW || state_r == S_PBW ||
                  state_r == S_BIW || state_r == S_QM1W || state_r == S_QM2W ||
                  state_r == S_CBW || state_r == S_CFW)
    else $error("multiplier running outside a wait state");

  a_accept_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !mul_run_r)
    else $error("item accepted while multiplier busy");
`endif

endmodule

// ===== dv/binomial_checker.sv =====
module binomial_checker
  import mbte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  mbte_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  mbte_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies and the pair latched by the last build
  logic [63:0]      mod_reg;
  logic [TOP_W-1:0] top_reg;
  logic [63:0]      tbl_mod;
  logic [63:0]      tbl_top;
  logic             tbl_ready;
  logic [63:0]      fact_tab [TABLE_DEPTH];
  logic [63:0]      inv_tab  [TABLE_DEPTH];

  mbte_out_t answer_q[$];

  function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic logic [63:0] powmod(input logic [63:0] base, input logic [63:0] e,
                                         input logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    base = base % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, base, m);
      base = mulmod(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  task automatic fill_tables();
    logic [63:0] m;
    int top;
    m = (mod_reg < 2) ? 64'd1 : mod_reg;
    top = int'(top_reg);
    fact_tab[0] = 64'd1 % m;
    for (int i = 1; i <= top; i++) fact_tab[i] = mulmod(fact_tab[i-1], 64'(i) % m, m);
    inv_tab[top] = powmod(fact_tab[top], m - 64'd2, m);
    for (int i = top; i >= 1; i--) inv_tab[i-1] = mulmod(inv_tab[i], 64'(i) % m, m);
    tbl_mod = m;
    tbl_top = 64'(top);
    tbl_ready = 1'b1;
  endtask

  // r > n wins over the range check
  function automatic mbte_out_t binom(input logic [63:0] n, input logic [63:0] r,
                                      input bit perm);
    mbte_out_t o;
    o = '{value: 64'd0, status: ST_OK};
    if (r > n) return o;
    if (n > tbl_top) begin
      o.status = ST_RANGE;
      return o;
    end
    if (perm) o.value = mulmod(fact_tab[n], inv_tab[n-r], tbl_mod);
    else o.value = mulmod(fact_tab[n], mulmod(inv_tab[r], inv_tab[n-r], tbl_mod), tbl_mod);
    return o;
  endfunction

  task automatic answer_for(input mbte_in_t it, output mbte_out_t o);
    logic [63:0] n, r;
    n = 64'(it.n_arg);
    r = 64'(it.r_arg);
    o = '{value: 64'd0, status: ST_OK};
    if (it.req_type == REQ_BUILD) begin
      fill_tables();
    end else if (it.req_type > REQ_STARS) begin
      // unknown request: zero, ok
    end else if (!tbl_ready) begin
      o.status = ST_NB;
    end else begin
      case (it.req_type)
        REQ_NCR: o = binom(n, r, 1'b0);
        REQ_NPR: o = binom(n, r, 1'b1);
        REQ_CAT: begin
          if (2 * n > tbl_top) o.status = ST_RANGE;
          else begin
            o = binom(2 * n, n, 1'b0);
            o.value = mulmod(o.value, powmod(n + 1, tbl_mod - 64'd2, tbl_mod), tbl_mod);
          end
        end
        default: begin
          if (r == 0) o.value = (n == 0) ? (64'd1 % tbl_mod) : 64'd0;
          else o = binom(n + r - 1, r - 1, 1'b0);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    mbte_out_t want;
    if (!rst_n) begin
      mod_reg = MOD_RESET;
      top_reg = TOP_RESET;
      tbl_ready = 1'b0;
      tbl_mod = 64'd1;
      tbl_top = 64'd0;
      answer_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MODULUS) mod_reg = cfg_wdata;
        else top_reg = cfg_wdata[TOP_W-1:0];
      end
      if (in_valid && !in_stall) begin
        answer_for(in_data, want);
        answer_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result: value %h status %0d", out_data.value, out_data.status);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (out_data.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, out_data.value);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import mbte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 40_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  mbte_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  mbte_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_MODULUS;
  logic [63:0] cfg_wdata = '0;
  int          pending;
  int          errors;

  bit          steady = 1'b0;  // no idling on either side in the closing stretch
  int          cur_top;        // top that random items are shaped around
  int          cycles = 0;

  always #5 clk = ~clk;

  modular_binomial_table_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  binomial_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .pending(pending), .errors(errors)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: runs of open cycles broken by random stall bursts; never stalls once steady
  initial begin
    @(posedge clk);
    forever begin
      if (steady) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if (!steady) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  end

  // one item; valid stays high into the next item unless a gap is taken
  task automatic send(input logic [2:0] req, input logic [31:0] n, input logic [31:0] r);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: req, n_arg: n, r_arg: r};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // both registers, written only while idle; top carries junk above bit 11
  task automatic write_regs(input logic [63:0] m, input int top);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODULUS;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_index <= CFG_TOP;
    cfg_wdata <= {$urandom, $urandom_range(0, 15), 12'(top)};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed queries around cur_top, some raw noise
  task automatic random_item();
    int pick, n, r;
    logic [2:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send(3'($urandom_range(REQ_NCR, 7)), $urandom, $urandom);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35) req = REQ_NCR;
      else if (pick < 60) req = REQ_NPR;
      else if (pick < 75) req = REQ_CAT;
      else req = REQ_STARS;
      if (req == REQ_CAT || req == REQ_STARS) begin
        n = $urandom_range(0, cur_top / 2 + 1);
        r = $urandom_range(0, cur_top / 2 + 1);
      end else begin
        n = $urandom_range(0, cur_top + 2);
        r = $urandom_range(0, n + 1);
      end
      send(req, 32'(n), 32'(r));
    end
  endtask

  // a phase: set registers, build, scramble the registers (the build latched them),
  // then random queries
  task automatic run_phase(input logic [63:0] m, input int top, input int count);
    write_regs(m, top);
    send(REQ_BUILD, $urandom, $urandom);
    drain();
    cur_top = top;
    write_regs({$urandom, $urandom}, $urandom_range(0, 4095));
    repeat (count) random_item();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // queries before any build, plus unknown codes
    send(REQ_NCR, 32'd3, 32'd1);
    send(REQ_NPR, 32'd0, 32'd0);
    send(REQ_CAT, 32'd1, 32'd0);
    send(REQ_STARS, 32'd0, 32'd0);
    send(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // full-depth build at reset settings
    send(REQ_BUILD, 32'd0, 32'd0);
    cur_top = 4095;
    send(REQ_NCR, 32'd4095, 32'd2000);
    send(REQ_NCR, 32'd3, 32'd5);                    // r above n
    send(REQ_NCR, 32'd4096, 32'd1);                 // out of range
    send(REQ_NCR, 32'd0, 32'd0);
    send(REQ_NCR, 32'd5, 32'hFFFF_FFFF);            // r above n, huge r
    send(REQ_NPR, 32'd10, 32'd3);
    send(REQ_NPR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);    // r equals n, n out of range
    send(REQ_NPR, 32'd4095, 32'd4095);
    send(REQ_CAT, 32'd0, 32'd0);
    send(REQ_CAT, 32'd2047, 32'd0);                 // 2n just below the top
    send(REQ_CAT, 32'd2048, 32'd0);                 // 2n just past the top
    send(REQ_CAT, 32'hFFFF_FFFF, 32'd0);
    send(REQ_STARS, 32'd0, 32'd0);                  // k zero, n zero
    send(REQ_STARS, 32'd5, 32'd0);                  // k zero, n nonzero
    send(REQ_STARS, 32'd3, 32'd4);
    send(REQ_STARS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(3'd6, 32'd1, 32'd1);
    send(3'd7, 32'd0, 32'hFFFF_FFFF);
    drain();

    // catalan where n+1 is a multiple of the modulus
    write_regs(64'd3, 10);
    send(REQ_BUILD, 32'd0, 32'd0);
    send(REQ_CAT, 32'd2, 32'd0);
    send(REQ_CAT, 32'd5, 32'd0);
    drain();

    cur_top = 4095;
    repeat (100) random_item();
    drain();

    run_phase(64'd2, 7, 100);
    run_phase(64'd7, 30, 100);
    run_phase(64'hFFFF_FFFF_FFFF_FFC5, 60, 100);   // largest 64-bit prime
    run_phase(64'd0, 5, 90);                       // acts as modulus one
    run_phase(64'd1, 3, 90);
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 40, 100);   // non-prime, all ones
    run_phase(64'd13, 0, 80);                      // single-entry table
    run_phase(64'd1000000007, 200, 100);
    steady = 1'b1;
    run_phase(64'd998244353, 100, 150);

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
